// ===== rtl/stw_pkg.sv =====
// Package with constants, payload types and control structs of the texture span walker.
`timescale 1ns / 1ps

package stw_pkg;

  localparam int SEGMENT_LEN = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_RUN     = 64;
  localparam int LINE_WIDTH  = 1024;

  localparam int COL_W   = 10;
  localparam int XW      = 11;
  localparam int LW_W    = 13;
  localparam int LEN_W   = $clog2(SEGMENT_LEN + 1);
  localparam int RUN_W   = $clog2(MAX_RUN + 1);
  localparam int LOG_W   = 4;
  localparam int TEX_W   = 20;
  localparam int SEL_W   = 3;
  localparam int MAX_LOG = 10;

  // Configuration register indexes.
  localparam logic CFG_TEX_WIDTH  = 1'b0;
  localparam logic CFG_TEX_HEIGHT = 1'b1;

  // Division steps of one segment.
  localparam logic [SEL_W-1:0] DIV_SU  = 3'd0;
  localparam logic [SEL_W-1:0] DIV_SV  = 3'd1;
  localparam logic [SEL_W-1:0] DIV_EU  = 3'd2;
  localparam logic [SEL_W-1:0] DIV_EV  = 3'd3;
  localparam logic [SEL_W-1:0] DIV_STU = 3'd4;
  localparam logic [SEL_W-1:0] DIV_STV = 3'd5;

  typedef struct packed {
    logic [9:0]         row;
    logic [9:0]         first_col;
    logic [9:0]         end_col;
    logic signed [31:0] u_over_z;
    logic signed [31:0] v_over_z;
    logic signed [31:0] inv_depth;
    logic signed [31:0] u_slope;
    logic signed [31:0] v_slope;
    logic signed [31:0] depth_slope;
  } stw_in_t;

  typedef struct packed {
    logic [9:0]         pixel_col;
    logic [9:0]         pixel_row;
    logic [19:0]        texel_index;
    logic signed [31:0] depth_value;
    logic               last_pixel;
    logic               run_cut;
  } stw_out_t;

  typedef struct packed {
    logic load;
    logic seg_init;
    logic mul;
    logic div_start;
    logic emit;
    logic next;
  } stw_cmd_t;

  typedef struct packed {
    logic more;
    logic div_done;
    logic div_last;
    logic slot_free;
    logic emit_last;
  } stw_sts_t;

endpackage

// ===== rtl/stw_if.sv =====
// Valid/ready channel interfaces for span items and pixel items.
`timescale 1ns / 1ps

interface stw_in_if import stw_pkg::*; ();
  logic    valid;
  logic    ready;
  stw_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stw_out_if import stw_pkg::*; ();
  logic     valid;
  logic     ready;
  stw_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/subaffine_texture_span_walker_top.sv =====
// Top level of the texture span walker: configuration registers, controller and datapath.
`timescale 1ns / 1ps

// One span item is taken at a time and yields up to 64 pixel items, one per cycle while
// the output side is ready within a segment's emit phase. Each segment of up to 16 pixels
// has an init and a multiply step, six divisions on one shared radix-2 divider, then its
// pixels; the divider sets the span time. Input ready returns after the last pixel of
// the span enters the output register, via the next and segment states back to idle.

module subaffine_texture_span_walker_top import stw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [LOG_W-1:0] cfg_data_i,
  stw_in_if.sink           in_if,
  stw_out_if.source        out_if
);

  logic [LOG_W-1:0] wl_q, hl_q;
  logic [LOG_W-1:0] wl, hl;
  stw_cmd_t         cmd;
  stw_sts_t         sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= LOG_W'(6);
      hl_q <= LOG_W'(6);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TEX_WIDTH:  wl_q <= cfg_data_i;
        CFG_TEX_HEIGHT: hl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Values above ten behave as ten.
  assign wl = (wl_q > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG) : wl_q;
  assign hl = (hl_q > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG) : hl_q;

  stw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_if.data),
    .wl_i        (wl),
    .hl_i        (hl),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );

endmodule

// ===== rtl/stw_div.sv =====
// Iterative signed 32-bit divider, one quotient bit per cycle, zero divisor gives zero.
`timescale 1ns / 1ps

module stw_div import stw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic [32:0] trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    trial  = {rem_q, quo_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      rem_d  = '0;
      quo_d  = a_i[31] ? (32'd0 - a_i) : a_i;
      dvs_d  = b_i[31] ? (32'd0 - b_i) : b_i;
      neg_d  = a_i[31] ^ b_i[31];
      zero_d = (b_i == 32'd0);
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 32'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  assign done_o = done_q;
  assign q_o    = zero_q ? 32'd0 : (neg_q ? (32'd0 - quo_q) : quo_q);

endmodule

// ===== rtl/stw_ctrl.sv =====
// Sequencing state machine of the span walker.
`timescale 1ns / 1ps

module stw_ctrl import stw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stw_sts_t sts_i,
  output stw_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEG   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DGO   = 3'd3;
  localparam logic [2:0] S_DWAIT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SEG;
        end
      end
      S_SEG: begin
        if (sts_i.more) begin
          cmd_o.seg_init = 1'b1;
          state_d        = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DGO;
      end
      S_DGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts_i.div_done) begin
          state_d = sts_i.div_last ? S_EMIT : S_DGO;
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            state_d = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        cmd_o.next = 1'b1;
        state_d    = S_SEG;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/stw_dp.sv =====
// Datapath: span registers, segment products, division steps and the pixel output register.
`timescale 1ns / 1ps

module stw_dp import stw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stw_in_t          in_data_i,
  input  logic [LOG_W-1:0] wl_i,
  input  logic [LOG_W-1:0] hl_i,
  input  stw_cmd_t         cmd_i,
  output stw_sts_t         sts_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output stw_out_t         out_data_o
);

  logic [9:0]       row_q;
  logic [XW-1:0]    x_q, x1_q;
  logic [31:0]      u_q, v_q, z_q, du_q, dv_q, dz_q;
  logic [31:0]      pu_q, pv_q, pz_q;
  logic [31:0]      su_q, sv_q, eu_q, ev_q, stu_q, stv_q;
  logic [LEN_W-1:0] len_q, o_q;
  logic [RUN_W-1:0] n_q, emit_q;
  logic             cut_q;
  logic [SEL_W-1:0] sel_q;
  logic             out_valid_q;
  stw_out_t         out_q;

  logic [9:0]       x1c;
  logic [XW-1:0]    total;
  logic [XW-1:0]    span_left;
  logic [LEN_W-1:0] len_new;
  logic [31:0]      div_a, div_b, div_q;
  logic             div_done;
  logic [31:0]      qs;
  logic [31:0]      ash_u, ash_v;
  logic [9:0]       rmask, cmask, trow, tcol;
  logic [TEX_W-1:0] texel;
  logic             last;

  // End column clamp and total pixel count of a new span, before the run limit.
  always_comb begin
    if (LW_W'(in_data_i.end_col) > LW_W'(LINE_WIDTH)) begin
      x1c = 10'(LINE_WIDTH);
    end else begin
      x1c = in_data_i.end_col;
    end
    total = XW'(x1c) - XW'(in_data_i.first_col);
  end

  always_comb begin
    span_left = x1_q - x_q;
    if (span_left > XW'(SEGMENT_LEN)) begin
      len_new = LEN_W'(SEGMENT_LEN);
    end else begin
      len_new = span_left[LEN_W-1:0];
    end
  end

  always_comb begin
    unique case (sel_q)
      DIV_SU:  begin div_a = u_q;          div_b = z_q;          end
      DIV_SV:  begin div_a = v_q;          div_b = z_q;          end
      DIV_EU:  begin div_a = u_q + pu_q;   div_b = z_q + pz_q;   end
      DIV_EV:  begin div_a = v_q + pv_q;   div_b = z_q + pz_q;   end
      DIV_STU: begin div_a = eu_q - su_q;  div_b = 32'(len_q);   end
      DIV_STV: begin div_a = ev_q - sv_q;  div_b = 32'(len_q);   end
      default: begin div_a = '0;           div_b = '0;           end
    endcase
  end

  stw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign qs = div_q << FRAC_BITS;

  // Texel address from the integer parts of the stepped coordinates.
  always_comb begin
    ash_u = 32'($signed(su_q) >>> FRAC_BITS);
    ash_v = 32'($signed(sv_q) >>> FRAC_BITS);
    rmask = 10'((11'd1 << hl_i) - 11'd1);
    cmask = 10'((11'd1 << wl_i) - 11'd1);
    trow  = ash_u[9:0] & rmask;
    tcol  = ash_v[9:0] & cmask;
    texel = (TEX_W'(trow) << wl_i) + TEX_W'(tcol);
    last  = (n_q + RUN_W'(1)) == emit_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q  <= in_data_i.row;
      x_q    <= XW'(in_data_i.first_col);
      x1_q   <= XW'(x1c);
      u_q    <= in_data_i.u_over_z;
      v_q    <= in_data_i.v_over_z;
      z_q    <= in_data_i.inv_depth;
      du_q   <= in_data_i.u_slope;
      dv_q   <= in_data_i.v_slope;
      dz_q   <= in_data_i.depth_slope;
      n_q    <= '0;
      emit_q <= (total > XW'(MAX_RUN)) ? RUN_W'(MAX_RUN) : total[RUN_W-1:0];
      cut_q  <= total > XW'(MAX_RUN);
    end
    if (cmd_i.seg_init) begin
      len_q <= len_new;
    end
    if (cmd_i.mul) begin
      pu_q  <= 32'(du_q * 32'(len_q));
      pv_q  <= 32'(dv_q * 32'(len_q));
      pz_q  <= 32'(dz_q * 32'(len_q));
      o_q   <= '0;
    end
    if (div_done) begin
      case (sel_q)
        DIV_SU:  su_q  <= qs;
        DIV_SV:  sv_q  <= qs;
        DIV_EU:  eu_q  <= qs;
        DIV_EV:  ev_q  <= qs;
        DIV_STU: stu_q <= div_q;
        default: stv_q <= div_q;
      endcase
    end
    if (cmd_i.emit) begin
      out_q.pixel_col   <= 10'(x_q + XW'(o_q));
      out_q.pixel_row   <= row_q;
      out_q.texel_index <= texel;
      out_q.depth_value <= z_q;
      out_q.last_pixel  <= last;
      out_q.run_cut     <= last & cut_q;
      z_q  <= z_q + dz_q;
      su_q <= su_q + stu_q;
      sv_q <= sv_q + stv_q;
      o_q  <= o_q + LEN_W'(1);
      n_q  <= n_q + RUN_W'(1);
    end
    if (cmd_i.next) begin
      x_q <= x_q + XW'(SEGMENT_LEN);
      u_q <= u_q + 32'(du_q * 32'(SEGMENT_LEN));
      v_q <= v_q + 32'(dv_q * 32'(SEGMENT_LEN));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.mul) begin
        sel_q <= DIV_SU;
      end else if (div_done) begin
        sel_q <= sel_q + SEL_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.more      = (x_q < x1_q) && (n_q < emit_q);
  assign sts_o.div_done  = div_done;
  assign sts_o.div_last  = (sel_q == DIV_STV);
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = ((o_q + LEN_W'(1)) == len_q) || last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== dv/subaffine_texture_span_walker_top_test.sv =====
// Self-checking testbench of the texture span walker: random and directed spans, pixel checks.
`timescale 1ns / 1ps

module subaffine_texture_span_walker_top_test;
  import stw_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 1000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [LOG_W-1:0] cfg_data_i = '0;

  stw_in_if  span_ch ();
  stw_out_if pixel_ch ();

  subaffine_texture_span_walker_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (span_ch.sink),
    .out_if    (pixel_ch.source)
  );

  always #2 clk_i = ~clk_i;

  stw_in_t    span_queue[$];
  stw_out_t   pixel_expect[$];
  logic [3:0] width_log2  = 4'd6;
  logic [3:0] height_log2 = 4'd6;
  bit         idle_on = 1'b1;
  int         error_count = 0;
  int         spans_sent = 0;
  int         pixels_seen = 0;
  int         cuts_seen = 0;
  int         cycle_count = 0;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         sink_hold = 0;
  bit         hold_done = 1'b0;

  // Truncating signed division with a zero quotient for a zero divisor.
  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    if (b == 32'd0) return 32'd0;
    ma = a[31] ? (32'd0 - a) : a;
    mb = b[31] ? (32'd0 - b) : b;
    q  = ma / mb;
    return (a[31] != b[31]) ? (32'd0 - q) : q;
  endfunction

  function automatic logic [31:0] asr_frac(logic [31:0] x);
    return $unsigned($signed(x) >>> FRAC_BITS);
  endfunction

  task automatic predict_span_pixels(stw_in_t s);
    logic [31:0] u, v, z, du, dv, dz, wl, hl, colmask, rowmask, scale;
    logic [31:0] x, x1, total, emit_n, len, su, sv, ez, eu, ev, stu, stv, ti, o, n;
    stw_out_t    p;
    u = s.u_over_z; v = s.v_over_z; z = s.inv_depth;
    du = s.u_slope; dv = s.v_slope; dz = s.depth_slope;
    wl = (width_log2 > 4'd10) ? 32'd10 : 32'(width_log2);
    hl = (height_log2 > 4'd10) ? 32'd10 : 32'(height_log2);
    colmask = (32'd1 << wl) - 32'd1;
    rowmask = (32'd1 << hl) - 32'd1;
    scale = 32'd1 << FRAC_BITS;
    x1 = 32'(s.end_col);
    if (x1 > LINE_WIDTH) x1 = LINE_WIDTH;
    if (x1 <= 32'(s.first_col)) return;
    total  = x1 - 32'(s.first_col);
    emit_n = (total > MAX_RUN) ? MAX_RUN : total;
    n = 0;
    for (x = 32'(s.first_col); x < x1 && n < emit_n; x += SEGMENT_LEN) begin
      len = x1 - x;
      if (len > SEGMENT_LEN) len = SEGMENT_LEN;
      su  = div_trunc(u, z) * scale;
      sv  = div_trunc(v, z) * scale;
      ez  = z + dz * len;
      eu  = div_trunc(u + du * len, ez) * scale;
      ev  = div_trunc(v + dv * len, ez) * scale;
      stu = div_trunc(eu - su, len);
      stv = div_trunc(ev - sv, len);
      for (o = 0; o < len && n < emit_n; o++) begin
        ti = ((asr_frac(su) & rowmask) << wl) + (asr_frac(sv) & colmask);
        p.pixel_col   = 10'(x + o);
        p.pixel_row   = s.row;
        p.texel_index = ti[19:0];
        p.depth_value = z;
        p.last_pixel  = (n + 1 == emit_n);
        p.run_cut     = (n + 1 == emit_n) && (total > MAX_RUN);
        pixel_expect.push_back(p);
        n++;
        z  += dz;
        su += stu;
        sv += stv;
      end
      u += du * SEGMENT_LEN;
      v += dv * SEGMENT_LEN;
    end
  endtask

  // Span driver: holds the front item until the walker takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    bit nxt_valid;
    if (!rst_ni) begin
      span_ch.valid <= 1'b0;
      span_ch.data  <= '0;
    end else begin
      nxt_valid = 1'b0;
      if (span_ch.valid && span_ch.ready) begin
        predict_span_pixels(span_ch.data);
        void'(span_queue.pop_front());
        spans_sent++;
      end else if (span_ch.valid) begin
        nxt_valid = 1'b1;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) src_gap--;
        else if (span_queue.size() > 0) begin
          if (idle_on && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 8);
          else nxt_valid = 1'b1;
        end
      end
      span_ch.valid <= nxt_valid;
      if (nxt_valid) span_ch.data <= span_queue[0];
    end
  end

  // Long receiver hold-off, counted here so the walker backs up onto its input.
  always @(posedge clk_i) begin
    if (sink_hold > 0) sink_hold--;
    else if (!hold_done && pixels_seen >= 40) begin
      sink_hold = 700;
      hold_done = 1'b1;
    end
  end

  // Pixel monitor and ready generator.
  always @(posedge clk_i or negedge rst_ni) begin
    stw_out_t want;
    bit       nxt_ready;
    if (!rst_ni) begin
      pixel_ch.ready <= 1'b0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        pixels_seen++;
        if (pixel_ch.data.run_cut) cuts_seen++;
        if (pixel_expect.size() == 0) begin
          $error("unexpected pixel item col=%0d row=%0d", pixel_ch.data.pixel_col,
                 pixel_ch.data.pixel_row);
          error_count++;
        end else begin
          want = pixel_expect.pop_front();
          if (pixel_ch.data.pixel_col !== want.pixel_col) begin
            $error("pixel_col expected %0d actual %0d", want.pixel_col,
                   pixel_ch.data.pixel_col);
            error_count++;
          end
          if (pixel_ch.data.pixel_row !== want.pixel_row) begin
            $error("pixel_row expected %0d actual %0d", want.pixel_row,
                   pixel_ch.data.pixel_row);
            error_count++;
          end
          if (pixel_ch.data.texel_index !== want.texel_index) begin
            $error("texel_index expected %0h actual %0h", want.texel_index,
                   pixel_ch.data.texel_index);
            error_count++;
          end
          if (pixel_ch.data.depth_value !== want.depth_value) begin
            $error("depth_value expected %0h actual %0h", want.depth_value,
                   pixel_ch.data.depth_value);
            error_count++;
          end
          if (pixel_ch.data.last_pixel !== want.last_pixel) begin
            $error("last_pixel expected %0b actual %0b", want.last_pixel,
                   pixel_ch.data.last_pixel);
            error_count++;
          end
          if (pixel_ch.data.run_cut !== want.run_cut) begin
            $error("run_cut expected %0b actual %0b", want.run_cut, pixel_ch.data.run_cut);
            error_count++;
          end
        end
      end
      nxt_ready = 1'b0;
      if (sink_hold > 0) nxt_ready = 1'b0;
      else if (sink_gap > 0) sink_gap--;
      else if (idle_on && $urandom_range(0, 5) == 0) sink_gap = $urandom_range(1, 8);
      else nxt_ready = 1'b1;
      pixel_ch.ready <= nxt_ready;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("subaffine_texture_span_walker_top_test failed");
      $finish;
    end
  end

  function automatic stw_in_t make_span(int unsigned row, int unsigned first, int unsigned last,
                                        logic [31:0] u, logic [31:0] v, logic [31:0] z,
                                        logic [31:0] du, logic [31:0] dv, logic [31:0] dz);
    stw_in_t s;
    s.row = 10'(row); s.first_col = 10'(first); s.end_col = 10'(last);
    s.u_over_z = u; s.v_over_z = v; s.inv_depth = z;
    s.u_slope = du; s.v_slope = dv; s.depth_slope = dz;
    return s;
  endfunction

  function automatic stw_in_t random_span();
    stw_in_t     s;
    int unsigned first, len, kind;
    logic [31:0] z, dz;
    first = $urandom_range(0, 1023);
    kind  = $urandom_range(0, 19);
    if (kind == 0) len = 0;
    else if (kind < 15) len = $urandom_range(1, 20);
    else if (kind < 18) len = $urandom_range(21, 80);
    else len = $urandom_range(0, 1023);
    if (kind == 19) s.end_col = 10'($urandom);
    else s.end_col = 10'((first + len > 1023) ? 1023 : first + len);
    s.row = 10'($urandom);
    s.first_col = 10'(first);
    if ($urandom_range(0, 3) == 0) begin
      z = $urandom; dz = $urandom;
    end else begin
      z  = $urandom_range(1, 32'h0000_4000);
      dz = 32'($signed($urandom_range(0, 64)) - 32);
    end
    s.inv_depth = z; s.depth_slope = dz;
    if ($urandom_range(0, 2) == 0) begin
      s.u_over_z = $urandom; s.v_over_z = $urandom;
      s.u_slope = $urandom; s.v_slope = $urandom;
    end else begin
      s.u_over_z = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      s.v_over_z = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      s.u_slope  = 32'($signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000);
      s.v_slope  = 32'($signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000);
    end
    return s;
  endfunction

  task automatic write_cfg(logic idx, logic [3:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TEX_WIDTH) width_log2 = val;
    else height_log2 = val;
  endtask

  task automatic wait_drained();
    while (span_queue.size() != 0 || span_ch.valid || pixel_expect.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  logic [3:0] width_set[7]  = '{4'd6, 4'd0, 4'd10, 4'd15, 4'd4, 4'd1, 4'd8};
  logic [3:0] height_set[7] = '{4'd6, 4'd0, 4'd10, 4'd3, 4'd15, 4'd10, 4'd5};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(CFG_TEX_WIDTH, width_set[ph]);
      write_cfg(CFG_TEX_HEIGHT, height_set[ph]);
      if (ph == 6) idle_on = 1'b0;
      if (ph == 0) begin
        // Empty spans, single pixels, cut runs, zero divisor and the overflowing quotient.
        span_queue.push_back(make_span(5, 100, 100, 1, 2, 3, 4, 5, 6));
        span_queue.push_back(make_span(7, 900, 3, 1, 2, 3, 4, 5, 6));
        span_queue.push_back(make_span(1023, 1022, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                       32'h0000_0100, 0, 0, 0));
        span_queue.push_back(make_span(0, 0, 1023, 32'h0100_0000, 32'h0080_0000,
                                       32'h0000_1000, 32'h0000_0100, 32'hFFFF_FF00, 1));
        span_queue.push_back(make_span(3, 10, 74, 32'h0010_0000, 32'h0020_0000,
                                       32'h0000_0800, 32'h100, 32'h200, 32'hFFFF_FFFF));
        span_queue.push_back(make_span(4, 10, 75, 32'h0010_0000, 32'h0020_0000,
                                       32'h0000_0800, 32'h100, 32'h200, 32'h2));
        span_queue.push_back(make_span(9, 200, 220, 32'h1234_5678, 32'h8765_4321, 0,
                                       32'h11, 32'h22, 0));
        span_queue.push_back(make_span(11, 300, 305, 32'h8000_0000, 32'h8000_0000,
                                       32'hFFFF_FFFF, 0, 0, 0));
        span_queue.push_back(make_span(12, 400, 417, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                       32'h7FFF_FFFF));
        span_queue.push_back(make_span(1023, 1000, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'h8000_0000));
        span_queue.push_back(make_span(0, 0, 1, 0, 0, 1, 0, 0, 0));
        span_queue.push_back(make_span(682, 341, 357, 32'hFFF0_0000, 32'h000F_0000,
                                       32'h0000_0010, 32'h1000, 32'hFFFF_F000, 0));
        wait_drained();
      end
      for (int i = 0; i < 48; i++) span_queue.push_back(random_span());
      wait_drained();
    end
    $display("Ran %0d spans over seven texture size settings, %0d pixels checked, %0d cut runs.",
             spans_sent, pixels_seen, cuts_seen);
    if (error_count == 0 && pixel_expect.size() == 0) begin
      $display("subaffine_texture_span_walker_top_test passed");
    end else begin
      $display("subaffine_texture_span_walker_top_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stw_pkg.sv
rtl/stw_if.sv
rtl/stw_div.sv
rtl/stw_ctrl.sv
rtl/stw_dp.sv
rtl/subaffine_texture_span_walker_top.sv
dv/subaffine_texture_span_walker_top_test.sv
